// ===== sv/grs_pkg.sv =====
// ----------------------------------------------------------------------------
// grs_pkg
// Shared types and constants for the generator run supervisor.
// ----------------------------------------------------------------------------
package grs_pkg;

  // item kinds carried in tuser
  localparam logic [1:0] CMD_TICK      = 2'd0;
  localparam logic [1:0] CMD_OVERWRITE = 2'd1;
  localparam logic [1:0] CMD_INIT      = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_ALARM_POLL = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ALARM_HOLD = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_STATE_POLL = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CHECKPOINT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LINK_LOSS  = 3'd4;
  localparam int unsigned CFG_DATA_W = 31;

  // reset values
  localparam logic [15:0] ALARM_POLL_RST = 16'd100;
  localparam logic [15:0] ALARM_HOLD_RST = 16'd2000;
  localparam logic [19:0] STATE_POLL_RST = 20'd10000;
  localparam logic [30:0] CHECKPOINT_RST = 31'd300000;
  localparam logic [30:0] LINK_LOSS_RST  = 31'd1800000;

  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned OUT_DATA_W = 72;

  typedef struct packed {
    logic [15:0] alarm_poll_ms;
    logic [15:0] alarm_hold_ms;
    logic [19:0] state_poll_ms;
    logic [30:0] checkpoint_ms;
    logic [30:0] link_loss_limit_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] now_ms;
    logic        force_req;
    logic        oil_lamp;
    logic        overload_lamp;
    logic        run_lamp;
    logic        bus_running;
    logic        manual_mode;
    logic        link_up;
    logic [63:0] total_value;
  } item_t;

  typedef struct packed {
    logic        run;
    logic        save_request;
    logic [63:0] save_value;
    logic        stop_request;
  } rt_res_t;

  // now - since as signed 32 bit: non-negative and at least period
  function automatic logic span_reached(input logic [31:0] now, input logic [31:0] since,
                                        input logic [30:0] period);
    logic [31:0] d;
    d = now - since;
    return !d[31] && (d[30:0] >= period);
  endfunction

endpackage

// ===== sv/generator_run_supervisor.sv =====
// ----------------------------------------------------------------------------
// generator_run_supervisor
// Alarm lamp debounce, run time accounting, checkpoint and stop requests.
// ----------------------------------------------------------------------------
// Order: the input register loads at the input accept edge, the state update
//   sits after it, and the result register loads when the item fires, that is
//   when no result is waiting or the waiting one is being taken.
// Throughput: one item per cycle; input stalls only while a result waits.
// Reset (rst, synchronous): both stages empty, all state and stamps zero,
//   configuration registers back to their defaults.
module generator_run_supervisor (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [31:0] now_ms, [32] force_req, [33] oil_lamp, [34] overload_lamp,
  // [35] run_lamp, [36] bus_running, [37] manual_mode, [38] link_up,
  // [102:39] total_value, [103] zero
  input  logic [grs_pkg::IN_DATA_W-1:0]     s_tdata,
  // [1:0] cmd
  input  logic [1:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [0] run, [1] oil_alarm, [2] overload_alarm, [3] save_request,
  // [67:4] save_value, [68] stop_request, [71:69] zero
  output logic [grs_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  logic                              cfg_we,
  input  logic [grs_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [grs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  grs_pkg::cfg_t    cfg;
  grs_pkg::item_t   in_item;
  grs_pkg::rt_res_t rt_res;
  logic             in_valid;
  logic             fire;
  logic [1:0]       alarm_next;

  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alarm_poll_ms      <= grs_pkg::ALARM_POLL_RST;
      cfg.alarm_hold_ms      <= grs_pkg::ALARM_HOLD_RST;
      cfg.state_poll_ms      <= grs_pkg::STATE_POLL_RST;
      cfg.checkpoint_ms      <= grs_pkg::CHECKPOINT_RST;
      cfg.link_loss_limit_ms <= grs_pkg::LINK_LOSS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        grs_pkg::REG_ALARM_POLL: cfg.alarm_poll_ms      <= cfg_data[15:0];
        grs_pkg::REG_ALARM_HOLD: cfg.alarm_hold_ms      <= cfg_data[15:0];
        grs_pkg::REG_STATE_POLL: cfg.state_poll_ms      <= cfg_data[19:0];
        grs_pkg::REG_CHECKPOINT: cfg.checkpoint_ms      <= cfg_data;
        grs_pkg::REG_LINK_LOSS:  cfg.link_loss_limit_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.cmd           <= s_tuser;
      in_item.now_ms        <= s_tdata[31:0];
      in_item.force_req     <= s_tdata[32];
      in_item.oil_lamp      <= s_tdata[33];
      in_item.overload_lamp <= s_tdata[34];
      in_item.run_lamp      <= s_tdata[35];
      in_item.bus_running   <= s_tdata[36];
      in_item.manual_mode   <= s_tdata[37];
      in_item.link_up       <= s_tdata[38];
      in_item.total_value   <= s_tdata[102:39];
    end
  end

  grs_alarm u_alarm (
    .clk        (clk),
    .rst        (rst),
    .en         (fire),
    .item       (in_item),
    .cfg        (cfg),
    .alarm_next (alarm_next)
  );

  grs_runtime u_runtime (
    .clk  (clk),
    .rst  (rst),
    .en   (fire),
    .item (in_item),
    .cfg  (cfg),
    .res  (rt_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {3'b000, rt_res.stop_request, rt_res.save_value, rt_res.save_request,
                  alarm_next[1], alarm_next[0], rt_res.run};
    end
  end

endmodule

// ===== sv/grs_alarm.sv =====
// ----------------------------------------------------------------------------
// grs_alarm
// Alarm lamp debouncer: samples oil and overload lamps at the alarm poll
// period and flips each debounced state after the hold time.
// ----------------------------------------------------------------------------
module grs_alarm (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  grs_pkg::item_t  item,
  input  grs_pkg::cfg_t   cfg,
  output logic [1:0]      alarm_next
);

  logic [31:0] poll_stamp, poll_stamp_next;
  logic [1:0]  alarm;
  logic [31:0] chg_stamp [2];
  logic [31:0] chg_stamp_next [2];
  logic [31:0] stamp_eff [2];
  logic [31:0] held [2];
  logic [1:0]  raw;
  logic [31:0] poll_gap;
  logic        poll_due;

  assign raw      = {item.overload_lamp, item.oil_lamp};
  assign poll_gap = item.now_ms - poll_stamp;
  // a zero stamp means no sample taken yet
  assign poll_due = (poll_stamp == 32'd0) || (poll_gap >= {16'd0, cfg.alarm_poll_ms});

  always_comb begin
    poll_stamp_next = poll_stamp;
    alarm_next      = alarm;
    for (int k = 0; k < 2; k++) begin
      chg_stamp_next[k] = chg_stamp[k];
      stamp_eff[k]      = (chg_stamp[k] == 32'd0) ? item.now_ms : chg_stamp[k];
      held[k]           = item.now_ms - stamp_eff[k];
    end
    if (item.cmd == grs_pkg::CMD_TICK && poll_due) begin
      poll_stamp_next = item.now_ms;
      for (int k = 0; k < 2; k++) begin
        if (raw[k] == alarm[k]) begin
          chg_stamp_next[k] = 32'd0;
        end else if (held[k] >= {16'd0, cfg.alarm_hold_ms}) begin
          alarm_next[k]     = ~alarm[k];
          chg_stamp_next[k] = 32'd0;
        end else begin
          chg_stamp_next[k] = stamp_eff[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_stamp   <= '0;
      alarm        <= '0;
      chg_stamp[0] <= '0;
      chg_stamp[1] <= '0;
    end else if (en) begin
      poll_stamp   <= poll_stamp_next;
      alarm        <= alarm_next;
      chg_stamp[0] <= chg_stamp_next[0];
      chg_stamp[1] <= chg_stamp_next[1];
    end
  end

endmodule

// ===== sv/grs_runtime.sv =====
// ----------------------------------------------------------------------------
// grs_runtime
// Run state tracker: run flag, wrapping 64-bit runtime total, checkpoint
// save requests and link loss stop request.
// ----------------------------------------------------------------------------
module grs_runtime (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  grs_pkg::item_t   item,
  input  grs_pkg::cfg_t    cfg,
  output grs_pkg::rt_res_t res
);

  logic [31:0] poll_stamp, poll_stamp_next;
  logic        run_flag, run_flag_next;
  logic        prev_run, prev_run_next;
  logic [63:0] total, total_next;
  logic [31:0] accrue_stamp, accrue_stamp_next;
  logic [31:0] save_stamp, save_stamp_next;
  logic        unsaved, unsaved_next;
  logic [31:0] loss_stamp, loss_stamp_next;

  logic        cur;
  logic [31:0] now;
  logic [31:0] poll_gap;
  logic [31:0] accrue_gap;
  logic        poll_due;
  logic        save;
  logic        stop;

  assign now        = item.now_ms;
  assign cur        = item.run_lamp | item.bus_running;
  assign poll_gap   = now - poll_stamp;
  assign accrue_gap = now - accrue_stamp;
  assign poll_due   = item.force_req || (poll_stamp == 32'd0) ||
                      (poll_gap >= {12'd0, cfg.state_poll_ms});

  always_comb begin
    poll_stamp_next   = poll_stamp;
    run_flag_next     = run_flag;
    prev_run_next     = prev_run;
    total_next        = total;
    accrue_stamp_next = accrue_stamp;
    save_stamp_next   = save_stamp;
    unsaved_next      = unsaved;
    loss_stamp_next   = loss_stamp;
    save              = 1'b0;
    stop              = 1'b0;
    case (item.cmd)
      grs_pkg::CMD_OVERWRITE: begin
        total_next        = item.total_value;
        save              = 1'b1;
        unsaved_next      = 1'b0;
        save_stamp_next   = now;
        accrue_stamp_next = now;
      end
      grs_pkg::CMD_INIT: begin
        prev_run_next     = 1'b0;
        accrue_stamp_next = now;
        save_stamp_next   = now;
        unsaved_next      = 1'b0;
        loss_stamp_next   = 32'd0;
        total_next        = item.total_value;
        run_flag_next     = cur;
      end
      grs_pkg::CMD_TICK: begin
        if (poll_due) begin
          poll_stamp_next = now;
          run_flag_next   = cur;
          if (!prev_run && cur) begin
            accrue_stamp_next = now;
            save_stamp_next   = now;
            unsaved_next      = 1'b0;
          end else if (prev_run && accrue_gap != 32'd0) begin
            total_next        = total + {32'd0, accrue_gap};
            accrue_stamp_next = now;
            unsaved_next      = 1'b1;
          end
          // periodic checkpoint while running, or final save on falling edge
          if (cur && unsaved_next &&
              grs_pkg::span_reached(now, save_stamp_next, cfg.checkpoint_ms)) begin
            save            = 1'b1;
            save_stamp_next = now;
            unsaved_next    = 1'b0;
          end
          if (prev_run && !cur && unsaved_next) begin
            save            = 1'b1;
            save_stamp_next = now;
            unsaved_next    = 1'b0;
          end
          if (!cur || !item.manual_mode || item.link_up) begin
            loss_stamp_next = 32'd0;
          end else if (loss_stamp == 32'd0) begin
            loss_stamp_next = now;
          end else if (grs_pkg::span_reached(now, loss_stamp, cfg.link_loss_limit_ms)) begin
            loss_stamp_next = 32'd0;
            stop            = 1'b1;
          end
          prev_run_next = cur;
        end
      end
      default: begin
      end
    endcase
  end

  assign res.run          = run_flag_next;
  assign res.save_request = save;
  assign res.save_value   = total_next;
  assign res.stop_request = stop;

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_stamp   <= '0;
      run_flag     <= 1'b0;
      prev_run     <= 1'b0;
      total        <= '0;
      accrue_stamp <= '0;
      save_stamp   <= '0;
      unsaved      <= 1'b0;
      loss_stamp   <= '0;
    end else if (en) begin
      poll_stamp   <= poll_stamp_next;
      run_flag     <= run_flag_next;
      prev_run     <= prev_run_next;
      total        <= total_next;
      accrue_stamp <= accrue_stamp_next;
      save_stamp   <= save_stamp_next;
      unsaved      <= unsaved_next;
      loss_stamp   <= loss_stamp_next;
    end
  end

endmodule

// ===== sv/grs_checker.sv =====
// ----------------------------------------------------------------------------
// grs_checker
// Port level checks for the generator run supervisor, bound to the top level.
// ----------------------------------------------------------------------------
module grs_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [grs_pkg::OUT_DATA_W-1:0] m_tdata
);

  // both stages empty straight after reset
  a_reset_empty : assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("pipeline not empty after reset");

  // input side only stalls when a result is waiting and not taken
  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output back-pressure");

  a_out_hold : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_pad_zero : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[71:69] == 3'b000)
    else $error("result padding not zero");

endmodule

bind generator_run_supervisor grs_checker u_grs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
